/* design/jvph_pkg.sv */
// Shared types and constants for the joint velocity / position hold controller.
package jvph_pkg;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_VEL  = 2'd1,
    ACT_ABS  = 2'd2,
    ACT_REL  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_MAX_VELOCITY    = 2'd0,
    REG_CORRECTION_GAIN = 2'd1,
    REG_HOLD_TOLERANCE  = 2'd2,
    REG_UNUSED          = 2'd3
  } reg_index_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned MaxVelW = 31;
  localparam int unsigned GainW = 16;
  localparam int unsigned TolW = 31;
  localparam int unsigned CfgW = 31;
  localparam int unsigned FracShift = 8;

  localparam logic [MaxVelW-1:0] MaxVelocityReset = 31'd32768;
  localparam logic [GainW-1:0] CorrectionGainReset = 16'd5120;
  localparam logic [TolW-1:0] HoldToleranceReset = 31'd1144;

endpackage

/* design/joint_velocity_position_hold.sv */
// Joint velocity controller with proportional position hold and deadband.
// A tick item's result passes the input register, then the result register; command
// items give no result. Throughput: one item per cycle; a tick item waits in the input
// register while the result register holds a result not yet taken. The single path
// input register -> gain multiply, round and clamp -> result register sets this figure.
// Reset: hold active at angle zero, no pending commands, speed zero, registers at defaults.
module joint_velocity_position_hold (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] command_value, [63:32] measured_angle
  input  logic [2:0]  s_axis_tuser,  // [1:0] action, [2] time_backward
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] velocity_cmd
  output logic        m_axis_tuser,  // [0] position_reset
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [jvph_pkg::CfgW-1:0] cfg_data_i
);

  localparam int unsigned W = jvph_pkg::ValueW;
  localparam int unsigned ProdW = jvph_pkg::GainW + W + 1;

  // configuration
  logic [jvph_pkg::MaxVelW-1:0] max_vel_q;
  logic [jvph_pkg::GainW-1:0]   gain_q;
  logic [jvph_pkg::TolW-1:0]    tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_vel_q <= jvph_pkg::MaxVelocityReset;
      gain_q    <= jvph_pkg::CorrectionGainReset;
      tol_q     <= jvph_pkg::HoldToleranceReset;
    end else if (cfg_we_i) begin
      unique case (jvph_pkg::reg_index_e'(cfg_index_i))
        jvph_pkg::REG_MAX_VELOCITY:    max_vel_q <= cfg_data_i[jvph_pkg::MaxVelW-1:0];
        jvph_pkg::REG_CORRECTION_GAIN: gain_q <= cfg_data_i[jvph_pkg::GainW-1:0];
        jvph_pkg::REG_HOLD_TOLERANCE:  tol_q <= cfg_data_i[jvph_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                   in_valid_q;
  jvph_pkg::action_e      in_action_q;
  logic signed [W-1:0]    in_cmd_q;
  logic signed [W-1:0]    in_angle_q;
  logic                   in_back_q;

  logic out_free;
  logic in_go;
  logic in_is_tick;

  assign in_is_tick    = (in_action_q == jvph_pkg::ACT_TICK);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign in_go         = in_valid_q && (!in_is_tick || out_free);
  assign s_axis_tready = !in_valid_q || in_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action_q <= jvph_pkg::action_e'(s_axis_tuser[1:0]);
      in_back_q   <= s_axis_tuser[2];
      in_cmd_q    <= s_axis_tdata[31:0];
      in_angle_q  <= s_axis_tdata[63:32];
    end
  end

  // controller state
  logic                vel_pend_q, abs_pend_q, rel_pend_q;
  logic signed [W-1:0] vel_val_q, abs_val_q, rel_val_q;
  logic signed [W-1:0] run_speed_q, hold_angle_q;
  logic                hold_q;

  logic                vel_pend_d, abs_pend_d, rel_pend_d;
  logic signed [W-1:0] vel_val_d, abs_val_d, rel_val_d;
  logic signed [W-1:0] run_speed_d, hold_angle_d;
  logic                hold_d;

  logic signed [W:0]   rel_sum;
  logic signed [W-1:0] rel_sat;

  assign rel_sum = {in_angle_q[W-1], in_angle_q} + {rel_val_q[W-1], rel_val_q};
  always_comb begin
    if (rel_sum[W] != rel_sum[W-1]) begin
      rel_sat = rel_sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      rel_sat = rel_sum[W-1:0];
    end
  end

  always_comb begin
    vel_pend_d   = vel_pend_q;
    abs_pend_d   = abs_pend_q;
    rel_pend_d   = rel_pend_q;
    vel_val_d    = vel_val_q;
    abs_val_d    = abs_val_q;
    rel_val_d    = rel_val_q;
    run_speed_d  = run_speed_q;
    hold_angle_d = hold_angle_q;
    hold_d       = hold_q;
    unique case (in_action_q)
      jvph_pkg::ACT_VEL: begin
        vel_pend_d = 1'b1;
        vel_val_d  = in_cmd_q;
      end
      jvph_pkg::ACT_ABS: begin
        abs_pend_d = 1'b1;
        abs_val_d  = in_cmd_q;
      end
      jvph_pkg::ACT_REL: begin
        rel_pend_d = 1'b1;
        rel_val_d  = in_cmd_q;
      end
      default: begin
        // tick: a backward jump drops speed and hold, keeps pending commands
        priority if (in_back_q) begin
          run_speed_d = '0;
          hold_d      = 1'b0;
        end else if (vel_pend_q) begin
          hold_d = 1'b0;
          if (run_speed_q != '0 && vel_val_q == '0) begin
            hold_d       = 1'b1;
            hold_angle_d = in_angle_q;
          end
          run_speed_d = vel_val_q;
          vel_pend_d  = 1'b0;
        end else if (abs_pend_q) begin
          hold_d       = 1'b1;
          hold_angle_d = abs_val_q;
          abs_pend_d   = 1'b0;
        end else if (rel_pend_q) begin
          hold_d       = 1'b1;
          hold_angle_d = rel_sat;
          rel_pend_d   = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_pend_q   <= 1'b0;
      abs_pend_q   <= 1'b0;
      rel_pend_q   <= 1'b0;
      vel_val_q    <= '0;
      abs_val_q    <= '0;
      rel_val_q    <= '0;
      run_speed_q  <= '0;
      hold_angle_q <= '0;
      hold_q       <= 1'b1;
    end else if (in_go) begin
      vel_pend_q   <= vel_pend_d;
      abs_pend_q   <= abs_pend_d;
      rel_pend_q   <= rel_pend_d;
      vel_val_q    <= vel_val_d;
      abs_val_q    <= abs_val_d;
      rel_val_q    <= rel_val_d;
      run_speed_q  <= run_speed_d;
      hold_angle_q <= hold_angle_d;
      hold_q       <= hold_d;
    end
  end

  // velocity output
  logic signed [W:0]     err;
  logic [W:0]            err_mag;
  logic [ProdW-1:0]      prod;
  logic [ProdW-1:0]      prod_rnd;
  logic [ProdW-jvph_pkg::FracShift-1:0] prod_sh;
  logic [W:0]            hold_mag;
  logic signed [W:0]     pre_clamp;
  logic signed [W:0]     lim;
  logic signed [W:0]     clamped;
  logic signed [W-1:0]   vel_out;

  assign err      = {hold_angle_d[W-1], hold_angle_d} - {in_angle_q[W-1], in_angle_q};
  assign err_mag  = err[W] ? (W + 1)'(0) - err : err;
  assign prod     = {{(ProdW-jvph_pkg::GainW){1'b0}}, gain_q} * {{(ProdW-W-1){1'b0}}, err_mag};
  assign prod_rnd = prod + ProdW'(1 << (jvph_pkg::FracShift - 1));
  assign prod_sh  = prod_rnd[ProdW-1:jvph_pkg::FracShift];
  // saturate magnitude at 2^31 before the sign goes back on
  assign hold_mag = (|prod_sh[ProdW-jvph_pkg::FracShift-1:W-1]) ?
                    {2'b01, {(W-1){1'b0}}} : {2'b00, prod_sh[W-2:0]};
  assign lim      = {2'b00, max_vel_q};

  always_comb begin
    if (hold_d) begin
      if (err_mag <= {2'b00, tol_q}) begin
        pre_clamp = '0;
      end else begin
        pre_clamp = err[W] ? (W + 1)'(0) - hold_mag : hold_mag;
      end
    end else begin
      pre_clamp = {run_speed_d[W-1], run_speed_d};
    end
    if (pre_clamp > lim) begin
      clamped = lim;
    end else if (pre_clamp < -lim) begin
      clamped = -lim;
    end else begin
      clamped = pre_clamp;
    end
    vel_out = clamped[W-1:0];
  end

  // result register
  logic                out_valid_q;
  logic signed [W-1:0] out_vel_q;
  logic                out_reset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_go && in_is_tick) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go && in_is_tick) begin
      out_vel_q   <= in_back_q ? '0 : vel_out;
      out_reset_q <= in_back_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_vel_q;
  assign m_axis_tuser  = out_reset_q;

endmodule

/* tb/sv/joint_velocity_position_hold_tb.sv */
// Self-checking stream testbench for the joint velocity / position hold controller.
`timescale 1ns / 100ps

module joint_velocity_position_hold_tb;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned PhaseItems = 250;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned LongHoldOff = 60;

  typedef struct {
    jvph_pkg::action_e act;
    logic [31:0]       cmd;
    logic [31:0]       angle;
    logic              back;
  } joint_item_t;

  typedef struct {
    logic [31:0] vel_cmd;
    logic        pos_reset;
  } joint_result_t;

  typedef struct {
    jvph_pkg::action_e act;
    logic [31:0]       cmd;
    logic [31:0]       angle;
    logic              back;
    bit                pinned;
    logic [31:0]       vel_cmd;
    logic              pos_reset;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // [31:0] command_value, [63:32] measured_angle
  logic [2:0]  s_axis_tuser = '0;  // [1:0] action, [2] time_backward
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // [31:0] velocity_cmd
  logic        m_axis_tuser;       // [0] position_reset
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [30:0] cfg_data_i = '0;

  // Controller mirror: configuration and state
  logic [30:0]        lim_vel = jvph_pkg::MaxVelocityReset;
  logic [15:0]        gain = jvph_pkg::CorrectionGainReset;
  logic [30:0]        tol = jvph_pkg::HoldToleranceReset;
  logic               vel_pend = 1'b0;
  logic signed [31:0] vel_val = '0;
  logic               abs_pend = 1'b0;
  logic signed [31:0] abs_val = '0;
  logic               rel_pend = 1'b0;
  logic signed [31:0] rel_val = '0;
  logic signed [31:0] speed = '0;
  logic               holding = 1'b1;
  logic signed [31:0] hold_at = '0;

  joint_result_t velocity_cmd_q[$];
  joint_result_t pin_res;
  bit            pin_on = 1'b0;
  bit            steady = 1'b0;
  bit            stall_req = 1'b0;
  logic [31:0]   track = '0;
  int unsigned   errors = 0;
  int unsigned   idle_cycles = 0;

  joint_velocity_position_hold dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report(input string what);
    errors++;
    if (errors <= 50) $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic logic [31:0] clamp_drive(input longint v);
    longint lim;
    lim = longint'(lim_vel);
    if (v > lim) return lim[31:0];
    if (v < -lim) return 32'(-lim);
    return v[31:0];
  endfunction

  // Gain times error, rounded half away from zero, zero inside the deadband
  function automatic logic [31:0] hold_drive(input logic signed [31:0] angle);
    longint err, mag, prod;
    err = longint'(hold_at) - longint'(angle);
    mag = (err < 0) ? -err : err;
    if (mag <= longint'(tol)) return '0;
    prod = (longint'(gain) * mag + 128) >>> 8;
    if (prod > 64'sd2147483647) prod = 64'sd2147483648;
    return clamp_drive((err < 0) ? -prod : prod);
  endfunction

  function automatic bit step_joint(input joint_item_t it, output joint_result_t res);
    longint sum;
    res = '{vel_cmd: '0, pos_reset: 1'b0};
    case (it.act)
      jvph_pkg::ACT_VEL: begin
        vel_pend = 1'b1;
        vel_val = it.cmd;
        return 1'b0;
      end
      jvph_pkg::ACT_ABS: begin
        abs_pend = 1'b1;
        abs_val = it.cmd;
        return 1'b0;
      end
      jvph_pkg::ACT_REL: begin
        rel_pend = 1'b1;
        rel_val = it.cmd;
        return 1'b0;
      end
      default: ;
    endcase
    // Time went backwards: drop speed and hold, keep pending commands
    if (it.back) begin
      speed = '0;
      holding = 1'b0;
      res.pos_reset = 1'b1;
      return 1'b1;
    end
    if (vel_pend) begin
      holding = 1'b0;
      if (speed != 0 && vel_val == 0) begin
        holding = 1'b1;
        hold_at = it.angle;
      end
      speed = vel_val;
      vel_pend = 1'b0;
    end else if (abs_pend) begin
      holding = 1'b1;
      hold_at = abs_val;
      abs_pend = 1'b0;
    end else if (rel_pend) begin
      sum = longint'($signed(it.angle)) + longint'(rel_val);
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      holding = 1'b1;
      hold_at = sum[31:0];
      rel_pend = 1'b0;
    end
    res.vel_cmd = holding ? hold_drive(it.angle) : clamp_drive(longint'(speed));
    return 1'b1;
  endfunction

  function automatic logic [31:0] near(input logic [31:0] c, input int unsigned spread);
    return 32'(longint'($signed(c)) + longint'($urandom_range(0, 2 * spread))
               - longint'(spread));
  endfunction

  // Mostly well-formed motion: angles walk, ticks land near the hold target
  function automatic joint_item_t make_item();
    joint_item_t it;
    int unsigned pick, spread;
    it.cmd = $urandom;
    it.angle = $urandom;
    it.back = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 55) it.act = jvph_pkg::ACT_TICK;
    else if (pick < 70) it.act = jvph_pkg::ACT_VEL;
    else if (pick < 85) it.act = jvph_pkg::ACT_ABS;
    else it.act = jvph_pkg::ACT_REL;
    case (it.act)
      jvph_pkg::ACT_TICK: begin
        it.back = ($urandom_range(0, 99) < 3);
        spread = (tol > 31'd1048576) ? 32'd1048576 : 32'(tol) + 32'(tol >> 2) + 32'd64;
        pick = $urandom_range(0, 9);
        if (pick == 0) it.angle = $urandom;
        else if (holding && pick <= 4) it.angle = near(hold_at, spread);
        else if (holding && pick == 5)
          it.angle = 32'(longint'(hold_at) + ($urandom_range(0, 1) ? 64'sd1 : -64'sd1)
                         * (longint'(tol) + longint'($urandom_range(0, 1))));
        else it.angle = near(track, 4096);
        track = it.angle;
      end
      jvph_pkg::ACT_VEL: begin
        pick = $urandom_range(0, 3);
        if (pick <= 1) it.cmd = '0;
        else if (pick == 2)
          it.cmd = near('0, (lim_vel > 31'h1FFF_FFFF) ? 32'h2000_0000 : 32'(lim_vel) * 2 + 1);
      end
      jvph_pkg::ACT_ABS: if ($urandom_range(0, 3) != 0) it.cmd = near(track, 65536);
      default: if ($urandom_range(0, 3) != 0) it.cmd = near('0, 65536);
    endcase
    return it;
  endfunction

  task automatic offer(input joint_item_t it, input int gap);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {it.angle, it.cmd};
    s_axis_tuser <= {it.back, it.act};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (velocity_cmd_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input jvph_pkg::reg_index_e idx, input logic [30:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [30:0] mv, input logic [15:0] g,
                              input logic [30:0] t, input bit poke_unused);
    write_reg(jvph_pkg::REG_MAX_VELOCITY, mv);
    write_reg(jvph_pkg::REG_CORRECTION_GAIN, {15'd0, g});
    write_reg(jvph_pkg::REG_HOLD_TOLERANCE, t);
    if (poke_unused) write_reg(jvph_pkg::REG_UNUSED, 31'($urandom));
    cfg_we_i <= 1'b0;
    lim_vel = mv;
    gain = g;
    tol = t;
  endtask

  always @(posedge clk_i) begin : watch_outputs
    joint_item_t   it;
    joint_result_t res, exp;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (velocity_cmd_q.size() == 0) begin
          report($sformatf("result %h/%b with nothing expected", m_axis_tdata, m_axis_tuser));
        end else begin
          exp = velocity_cmd_q.pop_front();
          if (m_axis_tdata !== exp.vel_cmd)
            report($sformatf("velocity_cmd %h, expected %h", m_axis_tdata, exp.vel_cmd));
          if (m_axis_tuser !== exp.pos_reset)
            report($sformatf("position_reset %b, expected %b", m_axis_tuser, exp.pos_reset));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.act = jvph_pkg::action_e'(s_axis_tuser[1:0]);
        it.back = s_axis_tuser[2];
        it.cmd = s_axis_tdata[31:0];
        it.angle = s_axis_tdata[63:32];
        if (step_joint(it, res))
          velocity_cmd_q.insert(velocity_cmd_q.size(), pin_on ? pin_res : res);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Result side: random back-pressure per item (none in steady phases), or one long hold-off on request
  initial begin : result_sink
    int hold;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        hold = LongHoldOff;
      end else begin
        hold = steady ? 0 : $urandom_range(0, 3);
      end
      repeat (hold) begin
        m_axis_tready <= 1'b0;
        @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    plan_row_t   plan [27];
    joint_item_t it;
    int          p, n;
    // After reset: hold at zero, gain 20.0, clamp 0.5, deadband 1144
    plan = '{
      '{jvph_pkg::ACT_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
      '{jvph_pkg::ACT_TICK, 32'h0000_0000, 32'd1144,      1'b0, 1'b1, 32'h0000_0000, 1'b0},
      '{jvph_pkg::ACT_TICK, 32'h0000_0000, 32'd1145,      1'b0, 1'b1, 32'hFFFF_A68C, 1'b0},
      '{jvph_pkg::ACT_TICK, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b1, 32'h0000_8000, 1'b0},
      '{jvph_pkg::ACT_TICK, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'hFFFF_8000, 1'b0},
      '{jvph_pkg::ACT_TICK, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
      '{jvph_pkg::ACT_VEL,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{jvph_pkg::ACT_ABS,  32'h0001_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{jvph_pkg::ACT_REL,  32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{jvph_pkg::ACT_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_8000, 1'b0},
      '{jvph_pkg::ACT_TICK, 32'h0000_0000, 32'h0001_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
      '{jvph_pkg::ACT_TICK, 32'h0000_0000, 32'h8000_1000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{jvph_pkg::ACT_VEL,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0,         1'b0},
      '{jvph_pkg::ACT_TICK, 32'h0000_0000, 32'h0002_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
      '{jvph_pkg::ACT_VEL,  32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{jvph_pkg::ACT_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_8000, 1'b0},
      '{jvph_pkg::ACT_REL,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{jvph_pkg::ACT_TICK, 32'h0000_0000, 32'h7FFF_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{jvph_pkg::ACT_ABS,  32'h0000_1234, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{jvph_pkg::ACT_TICK, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
      '{jvph_pkg::ACT_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{jvph_pkg::ACT_ABS,  32'h0000_0064, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{jvph_pkg::ACT_ABS,  32'h0003_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{jvph_pkg::ACT_TICK, 32'h0000_0000, 32'h0003_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{jvph_pkg::ACT_VEL,  32'h0000_0100, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{jvph_pkg::ACT_ABS,  32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
      '{jvph_pkg::ACT_TICK, 32'h0000_0000, 32'h0000_0005, 1'b0, 1'b0, 32'h0,         1'b0}
    };
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      it = '{act: plan[i].act, cmd: plan[i].cmd, angle: plan[i].angle, back: plan[i].back};
      pin_on = plan[i].pinned;
      pin_res = '{vel_cmd: plan[i].vel_cmd, pos_reset: plan[i].pos_reset};
      offer(it, $urandom_range(0, 3));
    end
    pin_on = 1'b0;

    for (p = 0; p < NumPhases; p++) begin
      // Hold the sender until every expected result is back, then retune
      drain();
      case (p)
        0: program_regs(31'h7FFF_FFFF, 16'hFFFF, 31'd0, 1'b0);
        1: program_regs(31'd0, 16'd0, 31'd0, 1'b0);
        2: program_regs(jvph_pkg::MaxVelocityReset, jvph_pkg::CorrectionGainReset,
                        jvph_pkg::HoldToleranceReset, 1'b0);
        3: program_regs(31'($urandom_range(1, 1 << 22)), 16'($urandom), 31'h7FFF_FFFF, 1'b0);
        default: program_regs(31'($urandom_range(1, 1 << 22)), 16'($urandom),
                              31'($urandom_range(0, 8192)), p == 5);
      endcase
      steady = (p == 1 || p == 2 || p == 6);
      if (p == 2) stall_req = 1'b1;
      for (n = 0; n < PhaseItems; n++) begin
        it = make_item();
        offer(it, steady ? 0 : $urandom_range(0, 3));
      end
    end
    drain();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
